FILE: sv/rgbhsl_pkg.sv
// rgbhsl_pkg: shared types, widths, a multiply-by-3840 helper and the
// restoring-division step for the rgb to hsl converter pipeline. No dependencies.

package rgbhsl_pkg;

  localparam int CH_W      = 8;
  localparam int HUE_W     = 15;
  localparam int FRAC_W    = 16;
  localparam int QUO_W     = 16;
  localparam int DIV_STEPS = QUO_W;

  // one lane of a pipelined restoring divider: partial remainder, dividend
  // bits still to consume shifted out at the top, quotient bits shifted in
  typedef struct packed {
    logic [CH_W-1:0]  rem;
    logic [QUO_W-1:0] quo;
    logic [CH_W-1:0]  dvs;
  } div_lane_t;

  typedef struct packed {
    div_lane_t         hue;
    div_lane_t         sat;
    logic [FRAC_W-1:0] light;
    logic              gray;
  } pix_t;

  function automatic logic [23:0] mul3840(input logic [CH_W-1:0] v);
    // 3840 = 4096 - 256
    return {4'b0, v, 12'b0} - {8'b0, v, 8'b0};
  endfunction

  function automatic div_lane_t div_step(input div_lane_t l);
    logic [CH_W:0] rem_w;
    div_lane_t     o;
    rem_w = {l.rem, l.quo[QUO_W-1]};
    o.dvs = l.dvs;
    if (rem_w >= {1'b0, l.dvs}) begin
      o.rem = CH_W'(rem_w - {1'b0, l.dvs});
      o.quo = {l.quo[QUO_W-2:0], 1'b1};
    end else begin
      o.rem = rem_w[CH_W-1:0];
      o.quo = {l.quo[QUO_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

FILE: sv/rgbhsl_front.sv
// rgbhsl_front: first pipeline stage; finds max/min, lightness, and sets up
// the hue and saturation dividers. Depends on rgbhsl_pkg.

module rgbhsl_front
  import rgbhsl_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  logic            vld_in,
  input  logic [CH_W-1:0] red,
  input  logic [CH_W-1:0] green,
  input  logic [CH_W-1:0] blue,
  output logic            vld_r,
  output pix_t            pix_r
);

  logic            vld_nxt;
  pix_t            pix_nxt;
  logic            mx_is_r;
  logic            mx_is_g;
  logic [CH_W-1:0] mx;
  logic [CH_W-1:0] mn;
  logic [CH_W-1:0] d;
  logic [CH_W:0]   s;
  logic [CH_W:0]   den_hi;
  logic [16:0]     light_w;
  logic [23:0]     m_d;
  logic [23:0]     num;
  logic [23:0]     sat_dvd;
  logic [CH_W-1:0] den;

  always_comb begin
    // ties go to red, then green
    mx_is_r = (red >= green) && (red >= blue);
    mx_is_g = !mx_is_r && (green >= blue);
    mx      = mx_is_r ? red : (mx_is_g ? green : blue);
    mn      = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    d       = mx - mn;
    s       = {1'b0, mx} + {1'b0, mn};
    light_w = {s, 8'b0} + {8'b0, s};
    m_d     = mul3840(d);

    if (mx_is_r) begin
      if (green >= blue) begin
        num = mul3840(green - blue);
      end else begin
        num = (m_d << 2) + (m_d << 1) - mul3840(blue - green);
      end
    end else if (mx_is_g) begin
      num = (m_d << 1) + mul3840(blue) - mul3840(red);
    end else begin
      num = (m_d << 2) + mul3840(red) - mul3840(green);
    end

    den_hi  = 9'd510 - s;
    den     = (s < 9'd255) ? s[CH_W-1:0] : den_hi[CH_W-1:0];
    sat_dvd = {d, 16'b0} - {16'b0, d};

    pix_nxt.hue   = '{rem: num[23:16], quo: num[15:0], dvs: d};
    pix_nxt.sat   = '{rem: sat_dvd[23:16], quo: sat_dvd[15:0], dvs: den};
    pix_nxt.light = light_w[16:1];
    pix_nxt.gray  = (d == '0);

    vld_nxt = load ? vld_in : vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pix_r <= pix_nxt;
    end
  end

endmodule

FILE: sv/rgbhsl_div_stage.sv
// rgbhsl_div_stage: one register stage of the two pipelined restoring
// dividers, STEPS quotient bits per lane. Depends on rgbhsl_pkg.

module rgbhsl_div_stage
  import rgbhsl_pkg::*;
#(
  parameter int STEPS = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  logic vld_in,
  input  pix_t pix_in,
  output logic vld_r,
  output pix_t pix_r
);

  logic vld_nxt;
  pix_t pix_nxt;

  always_comb begin
    pix_nxt = pix_in;
    for (int i = 0; i < STEPS; i++) begin
      pix_nxt.hue = div_step(pix_nxt.hue);
      pix_nxt.sat = div_step(pix_nxt.sat);
    end
    vld_nxt = load ? vld_in : vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pix_r <= pix_nxt;
    end
  end

endmodule

FILE: sv/rgb_to_hsl_converter_core.sv
// rgb_to_hsl_converter_core: top level, front stage followed by a chain of
// divider stages. Depends on rgbhsl_pkg, rgbhsl_front and rgbhsl_div_stage.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   input   | in_valid / in_ready  | in_red_in, in_green_in, in_blue_in
//   result  | out_valid / out_ready| out_hue_out, out_saturation_out,
//           |                      | out_lightness_out
//
// one front stage, then the 16-step restoring dividers for hue and saturation
// spread over the divider stages. one transaction per cycle is sustained while
// out_ready is high.
// reset clears every stage valid bit; payload registers are not reset.
// a stall at the output backs up only through full stages, so empty stages
// keep taking transactions; nothing is lost or repeated.

module rgb_to_hsl_converter_core
  import rgbhsl_pkg::*;
#(
  parameter int STEPS_PER_STAGE = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CH_W-1:0]   in_red_in,
  input  logic [CH_W-1:0]   in_green_in,
  input  logic [CH_W-1:0]   in_blue_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [HUE_W-1:0]  out_hue_out,
  output logic [FRAC_W-1:0] out_saturation_out,
  output logic [FRAC_W-1:0] out_lightness_out
);

  localparam int NS = (DIV_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  logic [NS:0] vld;
  logic [NS:0] adv;
  pix_t        pipe [NS:0];
  pix_t        last;

  // a stage may load when it is empty or its successor moves on
  always_comb begin
    adv[NS] = !vld[NS] || out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_ready = adv[0];

  rgbhsl_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (adv[0]),
    .vld_in (in_valid),
    .red    (in_red_in),
    .green  (in_green_in),
    .blue   (in_blue_in),
    .vld_r  (vld[0]),
    .pix_r  (pipe[0])
  );

  // the last stage takes whatever steps are left over
  for (genvar k = 1; k <= NS; k++) begin : g_div
    rgbhsl_div_stage #(
      .STEPS ((k * STEPS_PER_STAGE <= DIV_STEPS) ? STEPS_PER_STAGE :
              DIV_STEPS - (k - 1) * STEPS_PER_STAGE)
    ) u_div (
      .clk    (clk),
      .rst_n  (rst_n),
      .load   (adv[k]),
      .vld_in (vld[k-1]),
      .pix_in (pipe[k-1]),
      .vld_r  (vld[k]),
      .pix_r  (pipe[k])
    );
  end

  assign last               = pipe[NS];
  assign out_valid          = vld[NS];
  // gray pixels have no hue and no saturation
  assign out_hue_out        = last.gray ? '0 : last.hue.quo[HUE_W-1:0];
  assign out_saturation_out = last.gray ? '0 : last.sat.quo;
  assign out_lightness_out  = last.light;

  a_empty_out_ready : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while the output stage is empty");

  a_front_loads : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld[0])
    else $error("accepted transaction did not reach the front stage");

  a_zero_sat_zero_hue : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_saturation_out == '0) |-> (out_hue_out == '0))
    else $error("zero saturation with nonzero hue");

  a_hue_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hue_out < 15'd23040))
    else $error("hue beyond a full turn");

endmodule
